FILE: src/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Shared widths, sequence constants and the codes used by the sender window
// control and its descriptor store.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_COUNT = 16;
  localparam int SEQ_W     = $clog2(SEQ_COUNT);
  localparam int MAX_LEN   = 128;

  localparam int PAYLOAD_W = 32;
  localparam int LEN_W     = 8;
  localparam int STORE_W   = PAYLOAD_W + LEN_W;
  localparam int WIN_W     = 4;
  localparam int PERIOD_W  = 16;
  localparam int RETRY_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [2:0]       kind_t;
  typedef logic [1:0]       mode_t;

  localparam kind_t KIND_SEND    = 3'd0;
  localparam kind_t KIND_RESEND  = 3'd1;
  localparam kind_t KIND_REFUSED = 3'd2;
  localparam kind_t KIND_STATUS  = 3'd3;
  localparam kind_t KIND_FAILED  = 3'd4;

  localparam mode_t MODE_OFFER = 2'd0;
  localparam mode_t MODE_ACK   = 2'd1;
  localparam mode_t MODE_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES  = 2'd2;

  localparam logic [WIN_W-1:0]    WINDOW_RESET  = 4'd15;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd200;
  localparam logic [RETRY_W-1:0]  RETRIES_RESET = 8'd10;
  localparam logic [RETRY_W-1:0]  RETRY_MAX     = 8'd255;

endpackage

FILE: src/gbn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/go_back_n_sender.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender window control
// Each input transaction on s_axis is an offered message, a received
// acknowledgement or a time tick, selected by s_axis_tuser. The block keeps
// the window, a descriptor store per sequence number and the retransmission
// timer, and answers on m_axis with one or more result transactions, the
// final one of each input marked by m_axis_tlast.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user writes them only while the block is idle, which the block itself does
// not enforce; index 0 is the window size, 1 the timer period and 2 the retry limit.
// A simple input is captured in the idle state and its single result is
// registered in the execute state once the result register is free. A timer
// expiry walks the window one retransmission per cycle through the descriptor
// RAM while m_axis is not stalled. s_axis_tready is low while a transaction is
// being worked on.
// A stall on m_axis holds the result register and the walk; nothing is lost.
// Reset clears the window, timer, retry count, end-of-data and failure flags and loads the
// register defaults; the descriptor store needs no clearing.
// ----------------------------------------------------------------------------
module go_back_n_sender (
  input  logic                                 clk,
  input  logic                                 rst,
  // payload[31:0], msg_length[39:32], ack_seq[43:40], ack_ok[44]
  input  logic [gbn_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                           s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // seq[3:0], payload_out[35:4], length_out[43:36], window_base[47:44],
  // done_res[48]
  output logic [gbn_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // kind[2:0]
  output logic [2:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]            cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RSEND
  } state_t;

  state_t state;

  logic [gbn_pkg::WIN_W-1:0]     window_size;
  logic [gbn_pkg::PERIOD_W-1:0]  timer_period;
  logic [gbn_pkg::RETRY_W-1:0]   max_retries;

  gbn_pkg::seq_t                 base_seq;
  gbn_pkg::seq_t                 next_seq;
  logic [gbn_pkg::PERIOD_W-1:0]  timer_count;
  logic                          timer_running;
  logic [gbn_pkg::RETRY_W-1:0]   retry_count;
  logic                          end_of_data;
  logic                          failed;
  gbn_pkg::seq_t                 ptr;

  gbn_pkg::mode_t                in_mode;
  logic [gbn_pkg::PAYLOAD_W-1:0] in_payload;
  logic [gbn_pkg::LEN_W-1:0]     in_length;
  gbn_pkg::seq_t                 in_ack_seq;
  logic                          in_ack_ok;

  gbn_pkg::kind_t                out_kind;
  gbn_pkg::seq_t                 out_seq;
  logic [gbn_pkg::PAYLOAD_W-1:0] out_payload;
  logic [gbn_pkg::LEN_W-1:0]     out_length;
  logic                          out_last;
  gbn_pkg::seq_t                 out_base;
  logic                          out_done;
  logic                          out_valid;

  logic                          out_free;
  logic                          exec_fire;
  logic                          rsend_fire;
  gbn_pkg::seq_t                 in_flight;
  logic [gbn_pkg::WIN_W-1:0]     eff_window;
  logic                          window_full;
  logic                          offer_send;
  logic                          ack_accept;
  logic                          tick_expire;
  gbn_pkg::seq_t                 ack_base;
  logic [gbn_pkg::LEN_W-1:0]     clamp_length;
  logic [gbn_pkg::RETRY_W-1:0]   retry_inc;
  logic                          retry_fail;
  logic                          rsend_last;
  gbn_pkg::seq_t                 ram_raddr;
  logic [gbn_pkg::STORE_W-1:0]   ram_rdata;

  assign out_free   = !out_valid || m_axis_tready;
  assign exec_fire  = (state == S_EXEC) && out_free;
  assign rsend_fire = (state == S_RSEND) && out_free;
  assign in_flight  = next_seq - base_seq;
  assign rsend_last = (ptr + gbn_pkg::seq_t'(1)) == next_seq;

  always_comb begin
    eff_window = window_size;
    if (window_size == '0) begin
      eff_window = gbn_pkg::WIN_W'(1);
    end
    if ({1'b0, window_size} >= (gbn_pkg::WIN_W + 1)'(gbn_pkg::SEQ_COUNT)) begin
      eff_window = gbn_pkg::WIN_W'(gbn_pkg::SEQ_COUNT - 1);
    end
  end

  assign window_full = {1'b0, in_flight} >= (gbn_pkg::SEQ_W + 1)'(eff_window);
  assign offer_send  = !failed && (in_mode == gbn_pkg::MODE_OFFER) && !end_of_data &&
                       (in_length != '0) && !window_full;
  assign ack_accept  = in_ack_ok && ((in_ack_seq - base_seq) < in_flight);
  assign ack_base    = in_ack_seq + gbn_pkg::seq_t'(1);
  assign tick_expire = timer_running && (timer_count <= gbn_pkg::PERIOD_W'(1));
  assign clamp_length = (in_length > gbn_pkg::LEN_W'(gbn_pkg::MAX_LEN)) ?
                        gbn_pkg::LEN_W'(gbn_pkg::MAX_LEN) : in_length;
  assign retry_inc   = (retry_count < gbn_pkg::RETRY_MAX) ?
                       retry_count + gbn_pkg::RETRY_W'(1) : retry_count;
  assign retry_fail  = retry_inc > max_retries;

  always_comb begin
    if (state == S_EXEC) begin
      ram_raddr = base_seq;
    end else if (rsend_fire) begin
      ram_raddr = ptr + gbn_pkg::seq_t'(1);
    end else begin
      ram_raddr = ptr;
    end
  end

  gbn_ram #(
    .WIDTH (gbn_pkg::STORE_W),
    .DEPTH (gbn_pkg::SEQ_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (exec_fire && offer_send),
    .waddr (next_seq),
    .wdata ({clamp_length, in_payload}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_size   <= gbn_pkg::WINDOW_RESET;
      timer_period  <= gbn_pkg::PERIOD_RESET;
      max_retries   <= gbn_pkg::RETRIES_RESET;
      base_seq      <= '0;
      next_seq      <= '0;
      timer_count   <= '0;
      timer_running <= 1'b0;
      retry_count   <= '0;
      end_of_data   <= 1'b0;
      failed        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbn_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[gbn_pkg::WIN_W-1:0];
          gbn_pkg::REG_TIMER_PERIOD: timer_period <= cfg_data[gbn_pkg::PERIOD_W-1:0];
          gbn_pkg::REG_MAX_RETRIES:  max_retries  <= cfg_data[gbn_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_mode    <= s_axis_tuser;
            in_payload <= s_axis_tdata[31:0];
            in_length  <= s_axis_tdata[39:32];
            in_ack_seq <= s_axis_tdata[43:40];
            in_ack_ok  <= s_axis_tdata[44];
            state      <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_kind    <= gbn_pkg::KIND_STATUS;
            out_seq     <= '0;
            out_payload <= '0;
            out_length  <= '0;
            out_last    <= 1'b1;
            out_base    <= base_seq;
            out_done    <= end_of_data && (base_seq == next_seq);
            state       <= S_IDLE;
            if (failed) begin
              out_kind <= gbn_pkg::KIND_FAILED;
            end else if (in_mode == gbn_pkg::MODE_OFFER) begin
              if (end_of_data) begin
                out_kind <= gbn_pkg::KIND_REFUSED;
              end else if (in_length == '0) begin
                end_of_data <= 1'b1;
                out_done    <= base_seq == next_seq;
              end else if (window_full) begin
                out_kind <= gbn_pkg::KIND_REFUSED;
              end else begin
                if (base_seq == next_seq) begin
                  timer_count   <= timer_period;
                  timer_running <= 1'b1;
                end
                out_kind    <= gbn_pkg::KIND_SEND;
                out_seq     <= next_seq;
                out_payload <= in_payload;
                out_length  <= clamp_length;
                out_done    <= 1'b0;
                next_seq    <= next_seq + gbn_pkg::seq_t'(1);
              end
            end else if (in_mode == gbn_pkg::MODE_ACK) begin
              if (ack_accept) begin
                retry_count <= '0;
                base_seq    <= ack_base;
                out_base    <= ack_base;
                out_done    <= end_of_data && (ack_base == next_seq);
                if (ack_base != next_seq) begin
                  timer_count   <= timer_period;
                  timer_running <= 1'b1;
                end else begin
                  timer_count   <= '0;
                  timer_running <= 1'b0;
                end
              end
            end else if ((in_mode == gbn_pkg::MODE_TICK) && timer_running) begin
              if (!tick_expire) begin
                timer_count <= timer_count - gbn_pkg::PERIOD_W'(1);
              end else begin
                timer_count   <= timer_period;
                timer_running <= 1'b1;
                if (base_seq != next_seq) begin
                  out_valid <= 1'b0;
                  ptr       <= base_seq;
                  state     <= S_RSEND;
                end else begin
                  retry_count <= retry_inc;
                  if (retry_fail) begin
                    failed        <= 1'b1;
                    timer_running <= 1'b0;
                    timer_count   <= '0;
                  end
                end
              end
            end
          end
        end

        S_RSEND: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_kind    <= gbn_pkg::KIND_RESEND;
            out_seq     <= ptr;
            out_payload <= ram_rdata[gbn_pkg::PAYLOAD_W-1:0];
            out_length  <= ram_rdata[gbn_pkg::STORE_W-1:gbn_pkg::PAYLOAD_W];
            out_last    <= rsend_last;
            out_base    <= base_seq;
            out_done    <= end_of_data && (base_seq == next_seq);
            ptr         <= ptr + gbn_pkg::seq_t'(1);
            if (rsend_last) begin
              state       <= S_IDLE;
              retry_count <= retry_inc;
              if (retry_fail) begin
                failed        <= 1'b1;
                timer_running <= 1'b0;
                timer_count   <= '0;
              end
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'b0, out_done, out_base, out_length, out_payload, out_seq};

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender window control testbench
// Drives offers, acknowledgements and time ticks into the sender and keeps
// its own model of the window, descriptor store, timer and retry count. The
// model works out the result transactions of every accepted input, and a
// monitor compares each result on the output stream, field by field, with
// the oldest one still pending. Directed tests cover the window limits,
// ok-flag and range checks on acks, timer expiry, repeated retransmission,
// end of data and the sticky failure; random traffic under several register
// settings and random stalls on both streams follows.
// ----------------------------------------------------------------------------
module testbench;

  localparam gbn_pkg::mode_t MODE_UNUSED = 2'd3;
  localparam int             LONG_HOLD   = 300;

  typedef struct {
    gbn_pkg::kind_t                kind;
    gbn_pkg::seq_t                 seq;
    logic [gbn_pkg::PAYLOAD_W-1:0] payload;
    logic [gbn_pkg::LEN_W-1:0]     len;
    logic                          last;
    gbn_pkg::seq_t                 base;
    logic                          done;
  } sender_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [gbn_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]                      s_axis_tuser  = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [gbn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]                      m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_we        = 1'b0;
  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [gbn_pkg::CFG_W-1:0]       cfg_data      = '0;

  // Window model state and register copies.
  gbn_pkg::seq_t                 win_base = '0;
  gbn_pkg::seq_t                 win_next = '0;
  logic [gbn_pkg::PAYLOAD_W-1:0] desc_payload [gbn_pkg::SEQ_COUNT];
  logic [gbn_pkg::LEN_W-1:0]     desc_len     [gbn_pkg::SEQ_COUNT];
  logic [gbn_pkg::PERIOD_W-1:0]  tmr_count    = '0;
  logic                          tmr_run      = 1'b0;
  logic [gbn_pkg::RETRY_W-1:0]   retries      = '0;
  logic                          data_ended   = 1'b0;
  logic                          link_failed  = 1'b0;
  logic [gbn_pkg::WIN_W-1:0]     cfg_window   = gbn_pkg::WINDOW_RESET;
  logic [gbn_pkg::PERIOD_W-1:0]  cfg_period   = gbn_pkg::PERIOD_RESET;
  logic [gbn_pkg::RETRY_W-1:0]   cfg_retries  = gbn_pkg::RETRIES_RESET;

  sender_result_t pending_results [$];
  int error_count = 0;
  int tx_gap_max  = 0;
  int rx_gap_max  = 0;
  int hold_req    = 0;
  int holds_taken = 0;
  int rx_wait     = 0;

  go_back_n_sender i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic gbn_pkg::seq_t seq_gap(gbn_pkg::seq_t from_seq, gbn_pkg::seq_t to_seq);
    return gbn_pkg::seq_t'(to_seq - from_seq);
  endfunction

  function automatic int effective_window();
    int w;
    w = cfg_window;
    if (w == 0) w = 1;
    if (w >= gbn_pkg::SEQ_COUNT) w = gbn_pkg::SEQ_COUNT - 1;
    return w;
  endfunction

  function automatic sender_result_t plain_result(gbn_pkg::kind_t kind, gbn_pkg::seq_t seq,
                                                  logic [gbn_pkg::PAYLOAD_W-1:0] payload,
                                                  logic [gbn_pkg::LEN_W-1:0] len);
    sender_result_t r;
    r.kind    = kind;
    r.seq     = seq;
    r.payload = payload;
    r.len     = len;
    r.last    = 1'b0;
    r.base    = '0;
    r.done    = 1'b0;
    return r;
  endfunction

  function automatic void arm_timer();
    tmr_count = cfg_period;
    tmr_run   = 1'b1;
  endfunction

  // Advances the window model by one accepted input and queues its results.
  function automatic void predict_window_step(gbn_pkg::mode_t mode,
                                              logic [gbn_pkg::PAYLOAD_W-1:0] pay,
                                              logic [gbn_pkg::LEN_W-1:0] len,
                                              gbn_pkg::seq_t ack, logic ok);
    sender_result_t step_out [$];
    logic [gbn_pkg::LEN_W-1:0] clipped;
    gbn_pkg::seq_t s;
    if (link_failed) begin
      step_out.push_back(plain_result(gbn_pkg::KIND_FAILED, '0, '0, '0));
    end else if (mode == gbn_pkg::MODE_OFFER) begin
      if (data_ended) begin
        step_out.push_back(plain_result(gbn_pkg::KIND_REFUSED, '0, '0, '0));
      end else if (len == '0) begin
        data_ended = 1'b1;
        step_out.push_back(plain_result(gbn_pkg::KIND_STATUS, '0, '0, '0));
      end else if (seq_gap(win_base, win_next) >= effective_window()) begin
        step_out.push_back(plain_result(gbn_pkg::KIND_REFUSED, '0, '0, '0));
      end else begin
        clipped = (len > gbn_pkg::MAX_LEN) ? gbn_pkg::LEN_W'(gbn_pkg::MAX_LEN) : len;
        desc_payload[win_next] = pay;
        desc_len[win_next]     = clipped;
        if (win_base == win_next) arm_timer();
        step_out.push_back(plain_result(gbn_pkg::KIND_SEND, win_next, pay, clipped));
        win_next = gbn_pkg::seq_t'(win_next + 1'b1);
      end
    end else if (mode == gbn_pkg::MODE_ACK) begin
      if (ok && seq_gap(win_base, ack) < seq_gap(win_base, win_next)) begin
        retries   = '0;
        win_base  = gbn_pkg::seq_t'(ack + 1'b1);
        tmr_run   = 1'b0;
        tmr_count = '0;
        if (win_base != win_next) arm_timer();
      end
      step_out.push_back(plain_result(gbn_pkg::KIND_STATUS, '0, '0, '0));
    end else if (mode == gbn_pkg::MODE_TICK && tmr_run) begin
      if (tmr_count > 1) begin
        tmr_count = tmr_count - 1'b1;
        step_out.push_back(plain_result(gbn_pkg::KIND_STATUS, '0, '0, '0));
      end else begin
        arm_timer();
        for (s = win_base; s != win_next; s = gbn_pkg::seq_t'(s + 1'b1))
          step_out.push_back(plain_result(gbn_pkg::KIND_RESEND, s, desc_payload[s],
                                          desc_len[s]));
        if (step_out.size() == 0)
          step_out.push_back(plain_result(gbn_pkg::KIND_STATUS, '0, '0, '0));
        if (retries != gbn_pkg::RETRY_MAX) retries = retries + 1'b1;
        if (retries > cfg_retries) begin
          link_failed = 1'b1;
          tmr_run     = 1'b0;
          tmr_count   = '0;
        end
      end
    end else begin
      step_out.push_back(plain_result(gbn_pkg::KIND_STATUS, '0, '0, '0));
    end
    foreach (step_out[k]) begin
      step_out[k].last = (k == step_out.size() - 1);
      step_out[k].base = win_base;
      step_out[k].done = data_ended && (win_base == win_next);
      pending_results.push_back(step_out[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    sender_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0h tdata %h",
               $time, m_axis_tuser, m_axis_tdata);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
      check_field("seq", 32'(want.seq), 32'(m_axis_tdata[3:0]));
      check_field("payload_out", want.payload, m_axis_tdata[35:4]);
      check_field("length_out", 32'(want.len), 32'(m_axis_tdata[43:36]));
      check_field("last", 32'(want.last), 32'(m_axis_tlast));
      check_field("window_base", 32'(want.base), 32'(m_axis_tdata[47:44]));
      check_field("done_res", 32'(want.done), 32'(m_axis_tdata[48]));
    end
  endfunction

  // Result monitor and receiver stalls.
  always @(posedge clk) begin : result_monitor
    int g;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (holds_taken != hold_req) begin
        holds_taken   <= hold_req;
        rx_wait       <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait       <= rx_wait - 1;
        m_axis_tready <= (rx_wait == 1);
      end else if (m_axis_tvalid && m_axis_tready) begin
        g = $urandom_range(0, rx_gap_max);
        rx_wait       <= g;
        m_axis_tready <= (g == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(gbn_pkg::mode_t mode, logic [gbn_pkg::PAYLOAD_W-1:0] pay,
                           logic [gbn_pkg::LEN_W-1:0] len, gbn_pkg::seq_t ack, logic ok);
    int g;
    g = $urandom_range(0, tx_gap_max);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, ok, ack, len, pay};
    do @(posedge clk); while (!s_axis_tready);
    predict_window_step(mode, pay, len, ack, ok);
  endtask

  task automatic offer_msg(logic [gbn_pkg::PAYLOAD_W-1:0] pay, logic [gbn_pkg::LEN_W-1:0] len);
    send_item(gbn_pkg::MODE_OFFER, pay, len, gbn_pkg::seq_t'($urandom), 1'($urandom));
  endtask

  task automatic recv_ack(gbn_pkg::seq_t ack, logic ok);
    send_item(gbn_pkg::MODE_ACK, $urandom, gbn_pkg::LEN_W'($urandom), ack, ok);
  endtask

  task automatic time_tick();
    send_item(gbn_pkg::MODE_TICK, $urandom, gbn_pkg::LEN_W'($urandom),
              gbn_pkg::seq_t'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (gbn_pkg::SEQ_COUNT + 4) @(posedge clk);
  endtask

  task automatic set_config(logic [gbn_pkg::WIN_W-1:0] w, logic [gbn_pkg::PERIOD_W-1:0] p,
                            logic [gbn_pkg::RETRY_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= gbn_pkg::REG_WINDOW_SIZE;
    cfg_data  <= gbn_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_index <= gbn_pkg::REG_TIMER_PERIOD;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= gbn_pkg::REG_MAX_RETRIES;
    cfg_data  <= gbn_pkg::CFG_W'(r);
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_window  = w;
    cfg_period  = p;
    cfg_retries = r;
  endtask

  task automatic send_random_item();
    logic [gbn_pkg::PAYLOAD_W-1:0] pay;
    logic [gbn_pkg::LEN_W-1:0] len;
    gbn_pkg::seq_t ack;
    logic ok;
    gbn_pkg::mode_t mode;
    int pick;
    int outstanding;
    pay  = $urandom;
    len  = gbn_pkg::LEN_W'($urandom);
    ack  = gbn_pkg::seq_t'($urandom);
    ok   = 1'($urandom);
    outstanding = int'(seq_gap(win_base, win_next));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      mode = gbn_pkg::MODE_OFFER;
      if ($urandom_range(0, 9) == 0)
        len = gbn_pkg::LEN_W'($urandom_range(gbn_pkg::MAX_LEN + 1, 255));
      else len = gbn_pkg::LEN_W'($urandom_range(1, gbn_pkg::MAX_LEN));
    end else if (pick < 70) begin
      mode = gbn_pkg::MODE_ACK;
      if (outstanding > 0 && $urandom_range(0, 4) != 0) begin
        ack = gbn_pkg::seq_t'(win_base + $urandom_range(0, outstanding - 1));
        ok  = ($urandom_range(0, 9) != 0);
      end
    end else if (pick < 96) begin
      mode = gbn_pkg::MODE_TICK;
    end else begin
      mode = MODE_UNUSED;
    end
    send_item(mode, pay, len, ack, ok);
  endtask

  task automatic test_basic_flow();
    recv_ack(4'd0, 1'b1);
    time_tick();
    send_item(MODE_UNUSED, $urandom, gbn_pkg::LEN_W'($urandom), gbn_pkg::seq_t'($urandom),
              1'($urandom));
    offer_msg(32'h0000_0000, 8'd1);
    wait_drained();
    set_config(4'd15, 16'd2, 8'd255);
    offer_msg(32'hFFFF_FFFF, 8'd128);
    offer_msg(32'hA5A5_5A5A, 8'd255);
    offer_msg(32'h1234_5678, 8'd129);
    recv_ack(4'd0, 1'b0);
    recv_ack(4'd9, 1'b1);
    recv_ack(4'd0, 1'b1);
    time_tick();
    time_tick();
    recv_ack(4'd3, 1'b1);
    time_tick();
    wait_drained();
  endtask

  task automatic test_window_limits();
    set_config(4'd0, 16'd1, 8'd255);
    offer_msg($urandom, 8'd64);
    offer_msg($urandom, 8'd64);
    time_tick();
    recv_ack(gbn_pkg::seq_t'(win_next - 1'b1), 1'b1);
    wait_drained();
    set_config(4'd15, 16'd1, 8'd255);
    repeat (15) offer_msg($urandom, gbn_pkg::LEN_W'($urandom_range(1, gbn_pkg::MAX_LEN)));
    offer_msg($urandom, 8'd7);
    time_tick();
    recv_ack(gbn_pkg::seq_t'(win_next - 1'b1), 1'b1);
    wait_drained();
  endtask

  // A zero period fires on every tick, so each tick resends the window; with a
  // limit of 255 the repeated rounds never fail.
  task automatic test_retry_saturation();
    set_config(4'd2, 16'd0, 8'd255);
    tx_gap_max = 2;
    rx_gap_max = 2;
    offer_msg($urandom, 8'd100);
    repeat (20) time_tick();
    recv_ack(gbn_pkg::seq_t'(win_next - 1'b1), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(int count, logic [gbn_pkg::WIN_W-1:0] w,
                                     logic [gbn_pkg::PERIOD_W-1:0] p,
                                     logic [gbn_pkg::RETRY_W-1:0] r,
                                     int tx_max, int rx_max, logic squeeze);
    set_config(w, p, r);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    if (squeeze) hold_req <= hold_req + 1;
    repeat (count) send_random_item();
    wait_drained();
  endtask

  // End of data is permanent and so is a failure, so a run ends in one of
  // them: either the window drains to done, or retransmission fails.
  task automatic test_end_of_data();
    tx_gap_max = 6;
    rx_gap_max = 6;
    set_config(4'd15, 16'd2, 8'd0);
    recv_ack(gbn_pkg::seq_t'(win_next - 1'b1), 1'b1);
    offer_msg($urandom, 8'd10);
    offer_msg($urandom, 8'd20);
    offer_msg($urandom, 8'd30);
    offer_msg($urandom, 8'd0);
    offer_msg($urandom, 8'd5);
    recv_ack(win_base, 1'b1);
    if ($urandom_range(0, 1) == 1) begin
      recv_ack(gbn_pkg::seq_t'(win_next - 1'b1), 1'b1);
      offer_msg($urandom, 8'd1);
      time_tick();
      send_item(MODE_UNUSED, $urandom, gbn_pkg::LEN_W'($urandom),
                gbn_pkg::seq_t'($urandom), 1'($urandom));
    end else begin
      time_tick();
      time_tick();
      offer_msg($urandom, 8'd1);
      recv_ack(win_base, 1'b1);
      time_tick();
      send_item(MODE_UNUSED, $urandom, gbn_pkg::LEN_W'($urandom),
                gbn_pkg::seq_t'($urandom), 1'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_flow();
    test_window_limits();
    test_retry_saturation();
    test_random_traffic(90, 4'd15, 16'd3, 8'd255, 0, 0, 1'b0);
    test_random_traffic(50, 4'd1, 16'd1, 8'd255, 18, 18, 1'b0);
    test_random_traffic(80, 4'd7, 16'd5, 8'd200, 0, 6, 1'b1);
    test_random_traffic(40, 4'd0, 16'd2, 8'd255, 18, 0, 1'b0);
    test_random_traffic(40, 4'd12, 16'd65535, 8'd255, 6, 18, 1'b0);
    test_end_of_data();
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/gbn_pkg.sv
src/gbn_ram.sv
src/go_back_n_sender.sv
bench/testbench.sv
